@@ rtl/core/swd_host_transfer_engine_assert.svh @@
// assertion macros for the swd host rtl
`ifndef SWD_HOST_TRANSFER_ENGINE_ASSERT_SVH
`define SWD_HOST_TRANSFER_ENGINE_ASSERT_SVH

// checked on every clock edge outside reset
`define SWDH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SWDH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/swdh_pkg.sv @@
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types, constants and helpers of the swd host transfer engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swdh_pkg;

  localparam int DATA_BITS  = 32;
  localparam int RESET_ONES = 56;
  localparam int SEQ_BITS   = 16;
  localparam int ZERO_BITS  = 16;
  localparam int Q_DEPTH    = 2;

  localparam logic [15:0] SWITCH_SEQ = 16'h79E7;
  localparam logic [15:0] HP_RESET   = 16'd50;

  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_PARITY = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_FAULT  = 3'd3;
  localparam logic [2:0] ST_OTHER  = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_LRESET = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_HDR      = 4'd1,
    PH_TRN_IN   = 4'd2,
    PH_ACK      = 4'd3,
    PH_TRN_FAIL = 4'd4,
    PH_RDATA    = 4'd5,
    PH_TRN_END  = 4'd6,
    PH_TRN_WR   = 4'd7,
    PH_WDATA    = 4'd8,
    PH_RST1     = 4'd9,
    PH_RSEQ     = 4'd10,
    PH_RST2     = 4'd11,
    PH_RZERO    = 4'd12
  } phase_t;

  // one classified tick word
  typedef struct packed {
    cmd_t                 cmd;
    logic [7:0]           header;
    logic [7:0]           attempts;
    logic [DATA_BITS:0]   wdata;
    logic                 din;
  } qentry_t;

  function automatic logic [2:0] ack_status(input logic [2:0] ack);
    logic [2:0] st;
    st = ST_OTHER;
    if (ack == ACK_WAIT) st = ST_WAIT;
    else if (ack == ACK_FAULT) st = ST_FAULT;
    return st;
  endfunction

endpackage

@@ rtl/core/swdh_front.sv @@
// ----------------------------------------------------------------------------
// swdh_front
// Accepts tick words, builds header, parity and attempt budget, and queues
// them for the bit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swdh_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic                       in_port_select,
  input  logic [3:0]                 in_reg_address,
  input  logic [31:0]                in_write_data,
  input  logic [7:0]                 in_attempts,
  input  logic                       in_swdio_in,
  output logic                       q_valid,
  output swdh_pkg::qentry_t          q_data,
  input  logic                       q_pop
);

  localparam int PTR_W = $clog2(swdh_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(swdh_pkg::Q_DEPTH + 1);

  swdh_pkg::qentry_t q_mem [swdh_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  q_count_r;
  swdh_pkg::qentry_t entry;
  logic              push;
  logic              rw;
  logic              par;

  always_comb begin
    rw             = (in_mode == swdh_pkg::CMD_READ);
    par            = in_port_select ^ rw ^ in_reg_address[2] ^ in_reg_address[3];
    entry.cmd      = swdh_pkg::cmd_t'(in_mode);
    entry.header   = {1'b1, 1'b0, par, in_reg_address[3], in_reg_address[2], rw,
                      in_port_select, 1'b1};
    entry.attempts = (in_attempts == 8'd0) ? 8'd1 : in_attempts;
    entry.wdata    = {^in_write_data, in_write_data};
    entry.din      = in_swdio_in;
  end

  assign in_ready = (q_count_r != CNT_W'(swdh_pkg::Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_count_r != '0);
  assign q_data   = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   q_count_r <= q_count_r + 1'b1;
        2'b01:   q_count_r <= q_count_r - 1'b1;
        default: q_count_r <= q_count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/swdh_back.sv @@
// ----------------------------------------------------------------------------
// swdh_back
// Bit engine: one queued tick word per step, swclk divider, header, ack,
// data and line reset sequencing; state registers feed the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "swd_host_transfer_engine_assert.svh"

module swdh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_half_period,
  input  logic               q_valid,
  input  swdh_pkg::qentry_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_swclk,
  output logic               out_swdio_out,
  output logic               out_swdio_oe,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [2:0]         out_status,
  output logic [2:0]         out_last_ack,
  output logic [31:0]        out_read_data
);

  localparam int DB = swdh_pkg::DATA_BITS;

  logic [15:0]             half_period_r;
  swdh_pkg::phase_t        phase_r, phase_nxt;
  logic [6:0]              bit_index_r, bit_index_nxt;
  logic [DB:0]             shift_word_r, shift_word_nxt;
  logic [7:0]              header_r, header_nxt;
  logic [7:0]              attempts_r, attempts_nxt;
  logic [15:0]             div_r, div_nxt;
  logic                    clk_level_r, clk_level_nxt;
  logic                    drive_en_r, drive_en_nxt;
  logic                    drive_lvl_r, drive_lvl_nxt;
  logic [2:0]              ack_r, ack_nxt;
  logic                    parity_r, parity_nxt;
  logic                    is_read_r, is_read_nxt;
  logic [DB-1:0]           rx_word_r, rx_word_nxt;
  logic [2:0]              status_r, status_nxt;
  logic                    done_r, done_nxt;
  logic                    out_valid_r;

  logic                    step;
  logic [15:0]             h;
  logic [6:0]              bi_inc;
  logic                    go_enter;
  swdh_pkg::phase_t        enter_ph;
  logic                    go_finish;
  logic [2:0]              fin_st;
  logic [1:0]              drv;

  // {enable, level} driven at the start of a bit slot
  function automatic logic [1:0] slot_drive(input swdh_pkg::phase_t ph,
                                            input logic [6:0] bi,
                                            input logic [7:0] hb,
                                            input logic [DB:0] sw);
    logic [1:0] r;
    r = 2'b00;
    case (ph)
      swdh_pkg::PH_HDR:   r = {1'b1, hb[bi[2:0]]};
      swdh_pkg::PH_WDATA: r = {1'b1, (bi[5:0] <= 6'(DB)) ? sw[bi[5:0]] : 1'b0};
      swdh_pkg::PH_RST1,
      swdh_pkg::PH_RST2:  r = 2'b11;
      swdh_pkg::PH_RSEQ:  r = {1'b1, swdh_pkg::SWITCH_SEQ[4'd15 - bi[3:0]]};
      swdh_pkg::PH_RZERO: r = 2'b10;
      default:            r = 2'b00;
    endcase
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign h         = (half_period_r == 16'd0) ? 16'd1 : half_period_r;
  assign step      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = step;

  always_comb begin
    phase_nxt      = phase_r;
    bit_index_nxt  = bit_index_r;
    shift_word_nxt = shift_word_r;
    header_nxt     = header_r;
    attempts_nxt   = attempts_r;
    div_nxt        = div_r;
    clk_level_nxt  = clk_level_r;
    drive_en_nxt   = drive_en_r;
    drive_lvl_nxt  = drive_lvl_r;
    ack_nxt        = ack_r;
    parity_nxt     = parity_r;
    is_read_nxt    = is_read_r;
    rx_word_nxt    = rx_word_r;
    status_nxt     = status_r;
    done_nxt       = done_r;
    bi_inc         = bit_index_r + 7'd1;
    go_enter       = 1'b0;
    enter_ph       = swdh_pkg::PH_IDLE;
    go_finish      = 1'b0;
    fin_st         = swdh_pkg::ST_OK;
    drv            = 2'b00;

    if (step) begin
      done_nxt = 1'b0;
      if (phase_r == swdh_pkg::PH_IDLE) begin
        case (q_data.cmd)
          swdh_pkg::CMD_READ,
          swdh_pkg::CMD_WRITE: begin
            header_nxt   = q_data.header;
            is_read_nxt  = (q_data.cmd == swdh_pkg::CMD_READ);
            attempts_nxt = q_data.attempts;
            if (q_data.cmd == swdh_pkg::CMD_WRITE) begin
              shift_word_nxt = q_data.wdata;
            end
            go_enter = 1'b1;
            enter_ph = swdh_pkg::PH_HDR;
          end
          swdh_pkg::CMD_LRESET: begin
            go_enter = 1'b1;
            enter_ph = swdh_pkg::PH_RST1;
          end
          default: ;
        endcase
      end else if ({1'b0, div_r} + 17'd1 >= {1'b0, h}) begin
        if (!clk_level_r) begin
          // rising edge: sample the line; the closing turnarounds drive it low
          clk_level_nxt = 1'b1;
          div_nxt       = '0;
          case (phase_r)
            swdh_pkg::PH_ACK: begin
              if (bit_index_r[1:0] != 2'd3) begin
                ack_nxt = ack_r | (3'(q_data.din) << bit_index_r[1:0]);
              end
            end
            swdh_pkg::PH_RDATA: begin
              if (bit_index_r < 7'(DB)) begin
                shift_word_nxt[bit_index_r[5:0]] = shift_word_r[bit_index_r[5:0]] | q_data.din;
                parity_nxt = parity_r ^ q_data.din;
              end else begin
                shift_word_nxt[DB] = shift_word_r[DB] | q_data.din;
              end
            end
            swdh_pkg::PH_TRN_FAIL,
            swdh_pkg::PH_TRN_END,
            swdh_pkg::PH_TRN_WR: begin
              drive_en_nxt  = 1'b1;
              drive_lvl_nxt = 1'b0;
            end
            default: ;
          endcase
        end else begin
          // end of slot
          case (phase_r)
            swdh_pkg::PH_HDR: begin
              if (bi_inc >= 7'd8) begin
                go_enter = 1'b1;
                enter_ph = swdh_pkg::PH_TRN_IN;
              end
            end
            swdh_pkg::PH_TRN_IN: begin
              ack_nxt  = 3'd0;
              go_enter = 1'b1;
              enter_ph = swdh_pkg::PH_ACK;
            end
            swdh_pkg::PH_ACK: begin
              if (bi_inc >= 7'd3) begin
                go_enter = 1'b1;
                if (ack_r == swdh_pkg::ACK_OK) begin
                  if (is_read_r) begin
                    shift_word_nxt = '0;
                    parity_nxt     = 1'b0;
                    enter_ph       = swdh_pkg::PH_RDATA;
                  end else begin
                    enter_ph = swdh_pkg::PH_TRN_WR;
                  end
                end else begin
                  enter_ph = swdh_pkg::PH_TRN_FAIL;
                end
              end
            end
            swdh_pkg::PH_TRN_FAIL: begin
              if (attempts_r <= 8'd1) begin
                attempts_nxt = 8'd0;
                go_finish    = 1'b1;
                fin_st       = swdh_pkg::ack_status(ack_r);
              end else begin
                attempts_nxt = attempts_r - 8'd1;
                go_enter     = 1'b1;
                enter_ph     = swdh_pkg::PH_HDR;
              end
            end
            swdh_pkg::PH_RDATA: begin
              if (bi_inc > 7'(DB)) begin
                rx_word_nxt = shift_word_r[DB-1:0];
                go_enter    = 1'b1;
                enter_ph    = swdh_pkg::PH_TRN_END;
              end
            end
            swdh_pkg::PH_TRN_END: begin
              go_finish = 1'b1;
              fin_st    = (parity_r ^ shift_word_r[DB]) ? swdh_pkg::ST_PARITY
                                                        : swdh_pkg::ST_OK;
            end
            swdh_pkg::PH_TRN_WR: begin
              go_enter = 1'b1;
              enter_ph = swdh_pkg::PH_WDATA;
            end
            swdh_pkg::PH_WDATA: begin
              if (bi_inc > 7'(DB)) begin
                go_finish = 1'b1;
              end
            end
            swdh_pkg::PH_RST1: begin
              if (bi_inc >= 7'(swdh_pkg::RESET_ONES)) begin
                go_enter = 1'b1;
                enter_ph = swdh_pkg::PH_RSEQ;
              end
            end
            swdh_pkg::PH_RSEQ: begin
              if (bi_inc >= 7'(swdh_pkg::SEQ_BITS)) begin
                go_enter = 1'b1;
                enter_ph = swdh_pkg::PH_RST2;
              end
            end
            swdh_pkg::PH_RST2: begin
              if (bi_inc >= 7'(swdh_pkg::RESET_ONES)) begin
                go_enter = 1'b1;
                enter_ph = swdh_pkg::PH_RZERO;
              end
            end
            swdh_pkg::PH_RZERO: begin
              if (bi_inc >= 7'(swdh_pkg::ZERO_BITS)) begin
                go_finish = 1'b1;
              end
            end
            default: go_finish = 1'b1;
          endcase

          if (go_finish) begin
            phase_nxt     = swdh_pkg::PH_IDLE;
            bit_index_nxt = '0;
            clk_level_nxt = 1'b0;
            div_nxt       = '0;
            drive_en_nxt  = 1'b1;
            drive_lvl_nxt = 1'b0;
            status_nxt    = fin_st;
            done_nxt      = 1'b1;
          end else if (!go_enter) begin
            bit_index_nxt = bi_inc;
            clk_level_nxt = 1'b0;
            div_nxt       = '0;
            drv           = slot_drive(phase_r, bi_inc, header_nxt, shift_word_nxt);
            drive_en_nxt  = drv[1];
            drive_lvl_nxt = drv[0];
          end
        end
      end else begin
        div_nxt = div_r + 16'd1;
      end

      if (go_enter) begin
        phase_nxt     = enter_ph;
        bit_index_nxt = '0;
        clk_level_nxt = 1'b0;
        div_nxt       = '0;
        drv           = slot_drive(enter_ph, 7'd0, header_nxt, shift_word_nxt);
        drive_en_nxt  = drv[1];
        drive_lvl_nxt = drv[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= swdh_pkg::HP_RESET;
      phase_r       <= swdh_pkg::PH_IDLE;
      bit_index_r   <= '0;
      attempts_r    <= '0;
      div_r         <= '0;
      clk_level_r   <= 1'b0;
      drive_en_r    <= 1'b0;
      drive_lvl_r   <= 1'b0;
      ack_r         <= '0;
      parity_r      <= 1'b0;
      is_read_r     <= 1'b0;
      rx_word_r     <= '0;
      status_r      <= swdh_pkg::ST_OK;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_period_r <= cfg_half_period;
      end
      phase_r     <= phase_nxt;
      bit_index_r <= bit_index_nxt;
      attempts_r  <= attempts_nxt;
      div_r       <= div_nxt;
      clk_level_r <= clk_level_nxt;
      drive_en_r  <= drive_en_nxt;
      drive_lvl_r <= drive_lvl_nxt;
      ack_r       <= ack_nxt;
      parity_r    <= parity_nxt;
      is_read_r   <= is_read_nxt;
      rx_word_r   <= rx_word_nxt;
      status_r    <= status_nxt;
      done_r      <= done_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_word_r <= shift_word_nxt;
    header_r     <= header_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_swclk     = clk_level_r;
  assign out_swdio_out = drive_en_r & drive_lvl_r;
  assign out_swdio_oe  = drive_en_r;
  assign out_busy_res  = (phase_r != swdh_pkg::PH_IDLE);
  assign out_done_res  = done_r;
  assign out_status    = status_r;
  assign out_last_ack  = ack_r;
  assign out_read_data = rx_word_r;

  `SWDH_ASSERT(a_done_idle, done_r |-> (phase_r == swdh_pkg::PH_IDLE && !clk_level_r), "done while not idle or swclk high")
  `SWDH_ASSERT(a_rise_busy, $rose(clk_level_r) |-> (phase_r != swdh_pkg::PH_IDLE), "swclk rose while idle")
  `SWDH_ASSERT(a_stall_hold, (out_valid_r && !out_ready) |=> ($stable(phase_r) && $stable(bit_index_r) && $stable(div_r)), "engine advanced while result stalled")
  `SWDH_ASSERT_ALWAYS(a_step_room, step |-> (!out_valid_r || out_ready), "step with no room for the result")

endmodule

@@ rtl/core/swd_host_transfer_engine.sv @@
// result word registered when the engine steps on its tick word from the queue, then held until taken
// one tick word per cycle sustained while out_ready is high: the bit engine takes one queued word per step
// a two-entry queue parts the classifying front from the engine, the state registers hold the result
// synchronous active-low reset: swclk low, swdio released, idle, half period 50
// ----------------------------------------------------------------------------
// swd_host_transfer_engine
// Serial wire debug host: reads, writes with retry, and line reset, one
// system clock tick per input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swd_host_transfer_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_half_period,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic        in_port_select,
  input  logic [3:0]  in_reg_address,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_attempts,
  input  logic        in_swdio_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_swclk,
  output logic        out_swdio_out,
  output logic        out_swdio_oe,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [2:0]  out_last_ack,
  output logic [31:0] out_read_data
);

  logic              q_valid;
  logic              q_pop;
  swdh_pkg::qentry_t q_data;

  swdh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_port_select (in_port_select),
    .in_reg_address (in_reg_address),
    .in_write_data  (in_write_data),
    .in_attempts    (in_attempts),
    .in_swdio_in    (in_swdio_in),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop)
  );

  swdh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_half_period (cfg_half_period),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_swclk       (out_swclk),
    .out_swdio_out   (out_swdio_out),
    .out_swdio_oe    (out_swdio_oe),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_last_ack    (out_last_ack),
    .out_read_data   (out_read_data)
  );

endmodule
